FILE: rtl/owrse_pkg.sv
// ----------------------------------------------------------------------------
// owrse_pkg
// Shared types, codes and helpers for the 1-Wire ROM search decision core.
// ----------------------------------------------------------------------------
`default_nettype none

package owrse_pkg;

  // ROM ID geometry
  localparam int unsigned IdBits     = 64;
  localparam int unsigned IdxW       = $clog2(IdBits);
  localparam int unsigned BitPosW    = 7;
  localparam int unsigned FamMarkW   = 4;
  localparam int unsigned CrcW       = 8;
  // first bit position past the family code byte
  localparam int unsigned FamilyEnd  = 9;
  // reflected Dallas polynomial x^8+x^5+x^4+1
  localparam logic [CrcW-1:0] CrcPoly = 8'h8C;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_START   = 2'd1,
    REQ_TRIPLET = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_SEND     = 3'd0,
    ST_FOUND    = 3'd1,
    ST_NODEV    = 3'd2,
    ST_CRCERR   = 3'd3,
    ST_FINISHED = 3'd4,
    ST_BUSERR   = 3'd5,
    ST_CLEARED  = 3'd6,
    ST_IGNORED  = 3'd7
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic       first_bit;
    logic       second_bit;
    logic       taken_dir;
    logic       bus_error;
  } item_t;

  typedef struct packed {
    logic [IdBits-1:0]   rom_bits;
    logic [BitPosW-1:0]  prior_disc;
    logic [FamMarkW-1:0] family_mark;
    logic                search_done;
    logic [BitPosW-1:0]  bit_pos;
    logic [BitPosW-1:0]  pass_zero;
    logic [CrcW-1:0]     crc;
    logic                pass_active;
  } search_t;

  // search memory after reset: everything zero, bit position at 1
  localparam search_t SearchRst = '{
    rom_bits:    '0,
    prior_disc:  '0,
    family_mark: '0,
    search_done: 1'b0,
    bit_pos:     BitPosW'(1),
    pass_zero:   '0,
    crc:         '0,
    pass_active: 1'b0
  };

  typedef struct packed {
    logic [2:0]          status;
    logic                next_dir;
    logic [BitPosW-1:0]  bit_number;
    logic [IdBits-1:0]   rom_id;
    logic [FamMarkW-1:0] family_disc;
  } result_t;

  // One bit of the CRC-8, LSB first
  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] crc,
                                               input logic b);
    logic [CrcW-1:0] sh;
    sh = crc >> 1;
    if (crc[0] ^ b) begin
      sh = sh ^ CrcPoly;
    end
    return sh;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/onewire_rom_search_engine_core.sv
// ----------------------------------------------------------------------------
// onewire_rom_search_engine_core
// Decision core of a 1-Wire ROM enumeration search: one request beat in,
// one result beat out.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  in       to core    in_valid_i/in_stall_o   req_type, first_bit, second_bit,
//                                              taken_dir, bus_error
//  out      from core  out_valid_o/out_stall_i status, next_dir, bit_number,
//                                              rom_id, family_discrepancy
//
//  Each beat passes through an input register, then through the decision
//  logic and search memory update into the result register.
//  One beat is accepted per cycle while the output is not stalled.
//  Reset clears the search memory (bit position to 1) and both valid flags.
//  A stall on the output holds the result register and then the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search_engine_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic                          first_bit_i,
  input  wire logic                          second_bit_i,
  input  wire logic                          taken_dir_i,
  input  wire logic                          bus_error_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic                               next_dir_o,
  output logic [owrse_pkg::BitPosW-1:0]      bit_number_o,
  output logic [owrse_pkg::IdBits-1:0]       rom_id_o,
  output logic [owrse_pkg::FamMarkW-1:0]     family_discrepancy_o
);
  import owrse_pkg::*;

  logic    in_vld_q;
  item_t   item_q;
  logic    out_vld_q;
  result_t res_q;
  search_t st_q;
  search_t st_d;
  result_t res_d;
  logic    advance;
  logic    in_accept;

  // Move a beat forward when the result slot is free or being taken
  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Hold the incoming beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.req_type   <= req_type_i;
      item_q.first_bit  <= first_bit_i;
      item_q.second_bit <= second_bit_i;
      item_q.taken_dir  <= taken_dir_i;
      item_q.bus_error  <= bus_error_i;
    end
  end

  owrse_decide u_decide (
    .item_i (item_q),
    .st_i   (st_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  // Update search memory as the beat retires into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SearchRst;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
      if (in_vld_q) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign status_o             = res_q.status;
  assign next_dir_o           = res_q.next_dir;
  assign bit_number_o         = res_q.bit_number;
  assign rom_id_o             = res_q.rom_id;
  assign family_discrepancy_o = res_q.family_disc;

`ifndef SYNTH
  a_bitpos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.bit_pos != '0) && (st_q.bit_pos <= BitPosW'(IdBits)))
    else $error("bit position out of range");

  a_idle_bitpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.pass_active |-> (st_q.bit_pos == BitPosW'(1)))
    else $error("bit position not rewound outside a pass");

  a_done_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.search_done |-> (!st_q.pass_active && (st_q.prior_disc == '0)))
    else $error("finished search with open pass or pending discrepancy");

  a_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_vld_q) |=> out_vld_q)
    else $error("retired beat produced no result");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with a free slot");
`endif

endmodule

`default_nettype wire

FILE: rtl/owrse_decide.sv
// ----------------------------------------------------------------------------
// owrse_decide
// Next-state and result logic for one request beat of the ROM search.
// ----------------------------------------------------------------------------
`default_nettype none

module owrse_decide (
  input  owrse_pkg::item_t   item_i,
  input  owrse_pkg::search_t st_i,
  output owrse_pkg::search_t st_o,
  output owrse_pkg::result_t res_o
);
  import owrse_pkg::*;

  search_t             nxt;
  status_e             status;
  logic                pick_dir;
  logic                next_dir;
  logic [BitPosW-1:0]  cur_m1;
  logic [BitPosW-1:0]  nxt_m1;
  logic [CrcW-1:0]     crc_new;
  logic                zero_branch;

  assign cur_m1      = st_i.bit_pos - BitPosW'(1);
  assign crc_new     = crc_step(st_i.crc, item_i.taken_dir);
  assign zero_branch = !item_i.first_bit && !item_i.second_bit && !item_i.taken_dir;

  // Decode the request and update search memory
  always_comb begin
    nxt      = st_i;
    status   = ST_IGNORED;
    pick_dir = 1'b0;
    unique case (item_i.req_type)
      REQ_CLEAR: begin
        nxt.prior_disc  = '0;
        nxt.family_mark = '0;
        nxt.search_done = 1'b0;
        nxt.pass_active = 1'b0;
        nxt.bit_pos     = BitPosW'(1);
        status          = ST_CLEARED;
      end
      REQ_START: begin
        if (st_i.search_done) begin
          nxt.pass_active = 1'b0;
          status          = ST_FINISHED;
        end else begin
          nxt.bit_pos     = BitPosW'(1);
          nxt.pass_zero   = '0;
          nxt.crc         = '0;
          nxt.pass_active = 1'b1;
          status          = ST_SEND;
          pick_dir        = 1'b1;
        end
      end
      REQ_TRIPLET: begin
        if (st_i.pass_active) begin
          if (item_i.bus_error) begin
            nxt.pass_active = 1'b0;
            nxt.bit_pos     = BitPosW'(1);
            status          = ST_BUSERR;
          end else if (item_i.first_bit && item_i.second_bit) begin
            nxt.pass_active = 1'b0;
            nxt.bit_pos     = BitPosW'(1);
            status          = ST_NODEV;
          end else begin
            // note a discrepancy where the 0 branch was taken
            if (zero_branch) begin
              nxt.pass_zero = st_i.bit_pos;
              if (st_i.bit_pos < BitPosW'(FamilyEnd)) begin
                nxt.family_mark = st_i.bit_pos[FamMarkW-1:0];
              end
            end
            nxt.rom_bits[cur_m1[IdxW-1:0]] = item_i.taken_dir;
            nxt.crc = crc_new;
            if (st_i.bit_pos >= BitPosW'(IdBits)) begin
              // last bit: close the pass and check the CRC
              nxt.pass_active = 1'b0;
              nxt.bit_pos     = BitPosW'(1);
              if (crc_new != '0) begin
                status = ST_CRCERR;
              end else begin
                nxt.prior_disc = nxt.pass_zero;
                if (nxt.pass_zero == '0) begin
                  nxt.search_done = 1'b1;
                end
                status = ST_FOUND;
              end
            end else begin
              nxt.bit_pos = st_i.bit_pos + BitPosW'(1);
              status      = ST_SEND;
              pick_dir    = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Choose the direction for the next triplet
  assign nxt_m1 = nxt.bit_pos - BitPosW'(1);

  always_comb begin
    next_dir = 1'b0;
    if (pick_dir) begin
      if (nxt.bit_pos < nxt.prior_disc) begin
        next_dir = nxt.rom_bits[nxt_m1[IdxW-1:0]];
      end else begin
        next_dir = (nxt.prior_disc == nxt.bit_pos);
      end
    end
  end

  assign st_o              = nxt;
  assign res_o.status      = status;
  assign res_o.next_dir    = next_dir;
  assign res_o.bit_number  = nxt.bit_pos;
  assign res_o.rom_id      = nxt.rom_bits;
  assign res_o.family_disc = nxt.family_mark;

endmodule

`default_nettype wire
